### design/ddgp_pkg.sv
`timescale 1ns / 1ps
package ddgp_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 31;
    localparam int FWD_W   = 31;
    localparam int TURN_W  = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int DIF_W  = POS_W + 1;
    localparam int QP_W   = 2 * QUAT_W;
    localparam int QS_W   = QP_W + 2;
    localparam int VEC_W  = 36;
    localparam int ANG_W  = 32;
    localparam int DIFF_W = ANG_W + 1;
    localparam int ERR_W  = 31;
    localparam int MAG_W  = 34;
    localparam int COS_W  = 32;
    localparam int APROD_W = ERR_W + GAIN_W + 1;

    localparam logic signed [DIFF_W-1:0] ANG_PI      = 33'sd843314857;
    localparam logic signed [DIFF_W-1:0] ANG_TWO_PI  = 33'sd1686629713;
    localparam logic signed [DIFF_W-1:0] ANG_HALF_PI = 33'sd421657428;
    localparam logic [27:0] GAIN_INV_K = 28'd163008219;
    localparam logic [QS_W-1:0] ONE_Q28 = QS_W'(64'd268435456);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_LINEAR  = 8'd0,
        REG_GAIN_ANGULAR = 8'd1,
        REG_MAX_LINEAR   = 8'd2,
        REG_MAX_TURN     = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [MAG_W-1:0]         mag;
        logic signed [TURN_W-1:0] turn;
        logic                     ok;
    } ddgp_side_t;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:10] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
        32'sd1048571, 32'sd524287, 32'sd262144
    };

    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] r;
        if (i < 11)
            r = ATAN_TAB[4'(i)];
        else if (i <= 28)
            r = ANG_W'(1) <<< (28 - i);
        else
            r = '0;
        return r;
    endfunction

endpackage

### design/ddgp_if.sv
`timescale 1ns / 1ps
interface ddgp_in_if;
    logic valid;
    logic ready;
    logic signed [ddgp_pkg::POS_W-1:0]  pose_x;
    logic signed [ddgp_pkg::POS_W-1:0]  pose_y;
    logic signed [ddgp_pkg::QUAT_W-1:0] quat_x;
    logic signed [ddgp_pkg::QUAT_W-1:0] quat_y;
    logic signed [ddgp_pkg::QUAT_W-1:0] quat_z;
    logic signed [ddgp_pkg::QUAT_W-1:0] quat_w;
    logic signed [ddgp_pkg::POS_W-1:0]  goal_x;
    logic signed [ddgp_pkg::POS_W-1:0]  goal_y;

    modport source (output valid, pose_x, pose_y, quat_x, quat_y, quat_z, quat_w,
                    goal_x, goal_y, input ready);
    modport sink (input valid, pose_x, pose_y, quat_x, quat_y, quat_z, quat_w,
                  goal_x, goal_y, output ready);
endinterface

interface ddgp_out_if;
    logic valid;
    logic ready;
    logic [ddgp_pkg::FWD_W-1:0]         forward_speed;
    logic signed [ddgp_pkg::TURN_W-1:0] turn_rate;

    modport source (output valid, forward_speed, turn_rate, input ready);
    modport sink (input valid, forward_speed, turn_rate, output ready);
endinterface

interface ddgp_cfg_if;
    logic valid;
    logic ready;
    logic [ddgp_pkg::CFG_IDX_W-1:0]  index;
    logic [ddgp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/ddgp_vec_cordic.sv
`timescale 1ns / 1ps
module ddgp_vec_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [ddgp_pkg::VEC_W-1:0]  x_in,
    input  logic signed [ddgp_pkg::VEC_W-1:0]  y_in,
    output logic                               out_valid,
    output logic signed [ddgp_pkg::VEC_W-1:0]  mag,
    output logic signed [ddgp_pkg::ANG_W-1:0]  ang
);
    import ddgp_pkg::*;

    logic signed [VEC_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg [0:CORDIC_STEPS];
    logic                    zero_reg [0:CORDIC_STEPS];
    logic                    valid_reg [0:CORDIC_STEPS];

    logic signed [VEC_W-1:0] x0_next;
    logic signed [VEC_W-1:0] y0_next;
    logic signed [ANG_W-1:0] z0_next;

    // Vectors in the left half-plane are turned through pi first.
    always_comb
    begin
        x0_next = x_in;
        y0_next = y_in;
        z0_next = '0;
        if (x_in < 0)
        begin
            x0_next = -x_in;
            y0_next = -y_in;
            z0_next = (y_in >= 0) ? ANG_W'(ANG_PI) : ANG_W'(-ANG_PI);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan_step(i);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < CORDIC_STEPS; k++)
                valid_reg[k+1] <= valid_reg[k];
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign mag = zero_reg[CORDIC_STEPS] ? '0 : x_reg[CORDIC_STEPS];
    assign ang = zero_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];

endmodule

### design/ddgp_cos_cordic.sv
`timescale 1ns / 1ps
module ddgp_cos_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [ddgp_pkg::ERR_W-1:0]  err,
    input  ddgp_pkg::ddgp_side_t               side_in,
    output logic                               out_valid,
    output logic signed [ddgp_pkg::COS_W-1:0]  cos_out,
    output ddgp_pkg::ddgp_side_t               side_out
);
    import ddgp_pkg::*;

    logic signed [COS_W-1:0] x_reg [1:CORDIC_STEPS];
    logic signed [COS_W-1:0] y_reg [1:CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg [1:CORDIC_STEPS];
    ddgp_side_t              side_reg [1:CORDIC_STEPS];
    logic                    valid_reg [1:CORDIC_STEPS];

    logic signed [COS_W-1:0] x_start;
    logic signed [COS_W-1:0] y_start;
    logic signed [ANG_W-1:0] z_start;

    // Start from the inverse CORDIC gain so that x ends up as the plain cosine.
    assign x_start = $signed(COS_W'(GAIN_INV_K));
    assign y_start = '0;
    assign z_start = ANG_W'(err);

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [COS_W-1:0] xc;
        logic signed [COS_W-1:0] yc;
        logic signed [ANG_W-1:0] zc;
        logic signed [COS_W-1:0] xs;
        logic signed [COS_W-1:0] ys;
        ddgp_side_t              sc;

        if (i == 0)
        begin : g_first
            assign xc = x_start;
            assign yc = y_start;
            assign zc = z_start;
            assign sc = side_in;
        end
        else
        begin : g_rest
            assign xc = x_reg[i];
            assign yc = y_reg[i];
            assign zc = z_reg[i];
            assign sc = side_reg[i];
        end

        assign xs = xc >>> i;
        assign ys = yc >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= sc;
                if (zc >= 0)
                begin
                    x_reg[i+1] <= xc - ys;
                    y_reg[i+1] <= yc + xs;
                    z_reg[i+1] <= zc - atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= xc + ys;
                    y_reg[i+1] <= yc - xs;
                    z_reg[i+1] <= zc + atan_step(i);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= CORDIC_STEPS; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[1] <= in_valid;
            for (int k = 1; k < CORDIC_STEPS; k++)
                valid_reg[k+1] <= valid_reg[k];
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign cos_out   = x_reg[CORDIC_STEPS];
    assign side_out  = side_reg[CORDIC_STEPS];

endmodule

### design/ddgp_scale.sv
`timescale 1ns / 1ps
module ddgp_scale (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [ddgp_pkg::COS_W-1:0]  cos_in,
    input  ddgp_pkg::ddgp_side_t               side_in,
    input  logic [ddgp_pkg::GAIN_W-1:0]        gain_linear,
    input  logic [ddgp_pkg::LIM_W-1:0]         max_linear_speed,
    output logic                               out_valid,
    output logic [ddgp_pkg::FWD_W-1:0]         forward_speed,
    output logic signed [ddgp_pkg::TURN_W-1:0] turn_rate
);
    import ddgp_pkg::*;

    localparam int MLO_W  = 17;
    localparam int MHI_W  = MAG_W - MLO_W;
    localparam int MP_W   = MLO_W + 28;
    localparam int DSUM_W = MAG_W + 28 + 1;
    localparam int T_W    = MAG_W + GAIN_W - 8;
    localparam int C_W    = 21;
    localparam int TLO_W  = 21;
    localparam int TP_W   = TLO_W + C_W;
    localparam int PSUM_W = T_W + C_W + 1;

    logic [4:0] valid_reg;

    // Stage 1: partial products of the magnitude gain correction.
    logic [MP_W-1:0]          mlo_prod_reg;
    logic [MP_W-1:0]          mhi_prod_reg;
    logic signed [COS_W-9:0]  c1_reg;
    logic signed [TURN_W-1:0] turn1_reg;
    logic                     ok1_reg;
    // Stage 2: rounded distance.
    logic [MAG_W-1:0]         dist_reg;
    logic [C_W-1:0]           c2_reg;
    logic signed [TURN_W-1:0] turn2_reg;
    logic                     ok2_reg;
    // Stage 3: gain times distance.
    logic [T_W-1:0]           t_reg;
    logic [C_W-1:0]           c3_reg;
    logic signed [TURN_W-1:0] turn3_reg;
    logic                     ok3_reg;
    // Stage 4: partial products with the cosine.
    logic [TP_W-1:0]          tlo_prod_reg;
    logic [TP_W-1:0]          thi_prod_reg;
    logic signed [TURN_W-1:0] turn4_reg;
    logic                     ok4_reg;
    // Stage 5: result.
    logic [FWD_W-1:0]         fwd_reg;
    logic signed [TURN_W-1:0] turn5_reg;

    logic signed [COS_W-9:0]  c_next;
    logic [DSUM_W-1:0]        dsum;
    logic [2*MAG_W-1:0]       tprod;
    logic [PSUM_W-1:0]        psum;
    logic [PSUM_W-21:0]       p_val;
    logic [FWD_W-1:0]         fwd_next;

    assign c_next = (COS_W-8)'(cos_in >>> 8);

    assign dsum = (DSUM_W'(mhi_prod_reg) << MLO_W) + DSUM_W'(mlo_prod_reg)
                  + (DSUM_W'(1) << 27);
    assign tprod = (2*MAG_W)'(gain_linear) * (2*MAG_W)'(dist_reg);
    assign psum = (PSUM_W'(thi_prod_reg) << TLO_W) + PSUM_W'(tlo_prod_reg)
                  + (PSUM_W'(1) << 19);
    assign p_val = psum[PSUM_W-1:20];

    always_comb
    begin
        if (!ok4_reg)
            fwd_next = '0;
        else if (p_val > (PSUM_W-20)'(max_linear_speed))
            fwd_next = max_linear_speed;
        else
            fwd_next = p_val[FWD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mlo_prod_reg <= MP_W'(side_in.mag[MLO_W-1:0]) * MP_W'(GAIN_INV_K);
            mhi_prod_reg <= MP_W'(side_in.mag[MAG_W-1:MLO_W]) * MP_W'(GAIN_INV_K);
            c1_reg       <= c_next;
            turn1_reg    <= side_in.turn;
            ok1_reg      <= side_in.ok;

            dist_reg  <= dsum[MAG_W+27:28];
            c2_reg    <= c1_reg[C_W-1:0];
            turn2_reg <= turn1_reg;
            // A cosine that comes out zero or slightly negative gives no forward motion.
            ok2_reg   <= ok1_reg && (c1_reg > 0);

            t_reg     <= tprod[T_W+7:8];
            c3_reg    <= c2_reg;
            turn3_reg <= turn2_reg;
            ok3_reg   <= ok2_reg;

            tlo_prod_reg <= TP_W'(t_reg[TLO_W-1:0]) * TP_W'(c3_reg);
            thi_prod_reg <= TP_W'(t_reg[T_W-1:TLO_W]) * TP_W'(c3_reg);
            turn4_reg    <= turn3_reg;
            ok4_reg      <= ok3_reg;

            fwd_reg   <= fwd_next;
            turn5_reg <= turn4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    assign out_valid     = valid_reg[4];
    assign forward_speed = fwd_reg;
    assign turn_rate     = turn5_reg;

endmodule

### design/diff_drive_goto_point_controller_core.sv
`timescale 1ns / 1ps
// Go-to-goal velocity controller for a differential-drive robot. One pose and goal
// transfer in gives one command transfer out, in order; a new pose is taken in every
// cycle while the skid stage is empty. The pipeline has two front stages for the
// offsets and quaternion products, two vectoring CORDICs side by side (one stage per
// iteration plus a quadrant stage) for yaw and for distance and bearing, five stages
// for the heading-error wrap and the turn gain and clip, a rotation CORDIC of one
// stage per iteration for the cosine, five stages of split multiplies for the forward
// command, and the output register. A skid stage behind the output register lets the
// pipeline move on while a command waits to be taken. Gains and limits are written
// through the configuration channel, which is always ready; index 0 is the linear
// gain, 1 the angular gain, 2 the forward speed limit and 3 the turn limit, and other
// indexes are ignored.
module diff_drive_goto_point_controller_core (
    input  logic   clk,
    input  logic   rst_n,
    ddgp_in_if.sink    pose,
    ddgp_out_if.source cmd,
    ddgp_cfg_if.sink   cfg
);
    import ddgp_pkg::*;

    logic [GAIN_W-1:0] gain_linear_reg;
    logic [GAIN_W-1:0] gain_angular_reg;
    logic [LIM_W-1:0]  max_linear_reg;
    logic [LIM_W-1:0]  max_turn_reg;

    logic en;

    // Front stages.
    logic                     v1_reg;
    logic signed [DIF_W-1:0]  dx1_reg;
    logic signed [DIF_W-1:0]  dy1_reg;
    logic signed [QP_W-1:0]   qwz_reg;
    logic signed [QP_W-1:0]   qxy_reg;
    logic signed [QP_W-1:0]   qyy_reg;
    logic signed [QP_W-1:0]   qzz_reg;
    logic                     v2_reg;
    logic signed [DIF_W-1:0]  dx2_reg;
    logic signed [DIF_W-1:0]  dy2_reg;
    logic signed [QS_W-1:0]   num_reg;
    logic signed [QS_W-1:0]   den_reg;

    logic                     vec_valid;
    logic signed [VEC_W-1:0]  dist_mag;
    logic signed [ANG_W-1:0]  bearing;
    logic signed [ANG_W-1:0]  yaw;

    // Heading-error and turn stages.
    logic [4:0]               vw_reg;
    logic signed [DIFF_W-1:0] err1_reg;
    logic signed [DIFF_W-1:0] err2_reg;
    logic signed [DIFF_W-1:0] err3_reg;
    logic signed [ERR_W-1:0]  err4_reg;
    logic signed [ERR_W-1:0]  err5_reg;
    logic [MAG_W-1:0]         mag_reg [1:4];
    logic signed [APROD_W-1:0] aprod_reg;
    logic                     ok4_reg;
    ddgp_side_t               side5_reg;

    logic signed [DIFF_W-1:0] err2_next;
    logic signed [DIFF_W-1:0] err3_next;
    logic signed [APROD_W-1:0] around;
    logic signed [DIFF_W-1:0] ang_val;
    logic signed [DIFF_W-1:0] lim_val;
    logic signed [TURN_W-1:0] turn_next;

    logic                     cos_valid;
    logic signed [COS_W-1:0]  cos_val;
    ddgp_side_t               cos_side;

    logic                     pv;
    logic [FWD_W-1:0]         pfwd;
    logic signed [TURN_W-1:0] pturn;

    logic                     out_valid_reg;
    logic [FWD_W-1:0]         out_fwd_reg;
    logic signed [TURN_W-1:0] out_turn_reg;
    logic                     skid_valid_reg;
    logic [FWD_W-1:0]         skid_fwd_reg;
    logic signed [TURN_W-1:0] skid_turn_reg;

    assign en         = !skid_valid_reg;
    assign pose.ready = en;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_linear_reg  <= GAIN_W'(256);
            gain_angular_reg <= GAIN_W'(512);
            max_linear_reg   <= LIM_W'(65536);
            max_turn_reg     <= LIM_W'(131072);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GAIN_LINEAR:  gain_linear_reg  <= cfg.data[GAIN_W-1:0];
                REG_GAIN_ANGULAR: gain_angular_reg <= cfg.data[GAIN_W-1:0];
                REG_MAX_LINEAR:   max_linear_reg   <= cfg.data[LIM_W-1:0];
                REG_MAX_TURN:     max_turn_reg     <= cfg.data[LIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= DIF_W'(pose.goal_x) - DIF_W'(pose.pose_x);
            dy1_reg <= DIF_W'(pose.goal_y) - DIF_W'(pose.pose_y);
            qwz_reg <= QP_W'(pose.quat_w) * QP_W'(pose.quat_z);
            qxy_reg <= QP_W'(pose.quat_x) * QP_W'(pose.quat_y);
            qyy_reg <= QP_W'(pose.quat_y) * QP_W'(pose.quat_y);
            qzz_reg <= QP_W'(pose.quat_z) * QP_W'(pose.quat_z);

            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            num_reg <= (QS_W'(qwz_reg) + QS_W'(qxy_reg)) <<< 1;
            den_reg <= $signed(ONE_Q28) - ((QS_W'(qyy_reg) + QS_W'(qzz_reg)) <<< 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pose.valid;
            v2_reg <= v1_reg;
        end
    end

    ddgp_vec_cordic u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .x_in      (VEC_W'(den_reg)),
        .y_in      (VEC_W'(num_reg)),
        .out_valid (),
        .mag       (),
        .ang       (yaw)
    );

    ddgp_vec_cordic u_goal (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .x_in      (VEC_W'(dx2_reg)),
        .y_in      (VEC_W'(dy2_reg)),
        .out_valid (vec_valid),
        .mag       (dist_mag),
        .ang       (bearing)
    );

    // Two rounds of wrapping bring the error into [-pi, pi]; exactly +-pi stays.
    always_comb
    begin
        err2_next = err1_reg;
        if (err2_next > ANG_PI)
            err2_next = err2_next - ANG_TWO_PI;
        else if (err2_next < -ANG_PI)
            err2_next = err2_next + ANG_TWO_PI;
        err3_next = err2_reg;
        if (err3_next > ANG_PI)
            err3_next = err3_next - ANG_TWO_PI;
        else if (err3_next < -ANG_PI)
            err3_next = err3_next + ANG_TWO_PI;
    end

    assign around  = aprod_reg + (APROD_W'(1) <<< 19);
    assign ang_val = DIFF_W'(around >>> 20);
    assign lim_val = $signed({2'b00, max_turn_reg});

    always_comb
    begin
        if (ang_val > lim_val)
            turn_next = TURN_W'(lim_val);
        else if (ang_val < -lim_val)
            turn_next = TURN_W'(-lim_val);
        else
            turn_next = TURN_W'(ang_val);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err1_reg   <= DIFF_W'(bearing) - DIFF_W'(yaw);
            mag_reg[1] <= dist_mag[MAG_W-1:0];
            err2_reg   <= err2_next;
            mag_reg[2] <= mag_reg[1];
            err3_reg   <= err3_next;
            mag_reg[3] <= mag_reg[2];

            err4_reg   <= ERR_W'(err3_reg);
            aprod_reg  <= APROD_W'(ERR_W'(err3_reg)) * $signed({1'b0, gain_angular_reg});
            ok4_reg    <= (err3_reg < ANG_HALF_PI) && (err3_reg > -ANG_HALF_PI);
            mag_reg[4] <= mag_reg[3];

            err5_reg       <= err4_reg;
            side5_reg.mag  <= mag_reg[4];
            side5_reg.turn <= turn_next;
            side5_reg.ok   <= ok4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vw_reg <= '0;
        else if (en)
            vw_reg <= {vw_reg[3:0], vec_valid};
    end

    ddgp_cos_cordic u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vw_reg[4]),
        .err       (err5_reg),
        .side_in   (side5_reg),
        .out_valid (cos_valid),
        .cos_out   (cos_val),
        .side_out  (cos_side)
    );

    ddgp_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (cos_valid),
        .cos_in           (cos_val),
        .side_in          (cos_side),
        .gain_linear      (gain_linear_reg),
        .max_linear_speed (max_linear_reg),
        .out_valid        (pv),
        .forward_speed    (pfwd),
        .turn_rate        (pturn)
    );

    // The skid register only fills while the output register is stalled, and the
    // pipeline stops while it is full.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !cmd.ready)
        begin
            if (en && pv)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= en && pv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !cmd.ready)
        begin
            if (en && pv)
            begin
                skid_fwd_reg  <= pfwd;
                skid_turn_reg <= pturn;
            end
        end
        else if (skid_valid_reg)
        begin
            out_fwd_reg  <= skid_fwd_reg;
            out_turn_reg <= skid_turn_reg;
        end
        else
        begin
            out_fwd_reg  <= pfwd;
            out_turn_reg <= pturn;
        end
    end

    assign cmd.valid         = out_valid_reg;
    assign cmd.forward_speed = out_fwd_reg;
    assign cmd.turn_rate     = out_turn_reg;

`ifndef SYNTHESIS
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a command while the output is empty");

    a_fwd_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_fwd_reg <= max_linear_reg))
        else $error("forward speed above its limit");

    a_turn_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((DIFF_W'(out_turn_reg) <= lim_val)
                           && (DIFF_W'(out_turn_reg) >= -lim_val)))
        else $error("turn rate outside its limit");
`endif

endmodule

### test/ddgp_checker.sv
`timescale 1ns / 1ps
module ddgp_checker (
    input  logic       clk,
    input  logic       rst_n,
    ddgp_in_if         pose,
    ddgp_out_if        cmd,
    ddgp_cfg_if        cfg,
    output int         fail_count,
    output int         pending
);
    import ddgp_pkg::*;

    typedef struct {
        logic [FWD_W-1:0]         fwd;
        logic signed [TURN_W-1:0] turn;
    } command_t;

    command_t  expected_cmds[$];
    longint    gain_lin;
    longint    gain_ang;
    longint    lim_fwd;
    longint    lim_turn;
    int        cmds_seen;

    localparam longint PI_Q28      = 843314857;
    localparam longint TWO_PI_Q28  = 1686629713;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint INV_K       = 163008219;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arc_step(int i);
        longint tab[11] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                            8385879, 4193963, 2097109, 1048571, 524287, 262144};
        if (i < 11)
            return tab[i];
        else if (i <= 28)
            return longint'(1) << (28 - i);
        return 0;
    endfunction

    // Vectoring rotation: returns the angle of (x, y); the magnitude comes back in mag.
    function automatic longint vector_angle(longint x, longint y, output longint mag);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q28 : -PI_Q28;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += arc_step(i);
            end
            else
            begin
                x -= ys; y += xs; z -= arc_step(i);
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint cosine_q28(longint z);
        longint x;
        longint y;
        longint xs;
        longint ys;
        x = INV_K;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= arc_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += arc_step(i);
            end
        end
        return x;
    endfunction

    function automatic command_t steer_command(longint px, longint py, longint qx,
                                               longint qy, longint qz, longint qw,
                                               longint gx, longint gy);
        command_t r;
        longint   num;
        longint   den;
        longint   mag;
        longint   dummy;
        longint   yaw;
        longint   bearing;
        longint   err;
        longint   ang;
        longint   fwd;
        longint   c;
        longint unsigned range_q16;
        longint unsigned t;
        longint unsigned p;
        num = 2 * (qw * qz + qx * qy);
        den = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
        yaw = vector_angle(den, num, dummy);
        bearing = vector_angle(gx - px, gy - py, mag);
        err = bearing - yaw;
        for (int k = 0; k < 2; k++)
        begin
            if (err > PI_Q28) err -= TWO_PI_Q28;
            if (err < -PI_Q28) err += TWO_PI_Q28;
        end
        ang = floor_shift(gain_ang * err + (longint'(1) << 19), 20);
        if (ang > lim_turn) ang = lim_turn;
        if (ang < -lim_turn) ang = -lim_turn;
        fwd = 0;
        if (err < HALF_PI_Q28 && err > -HALF_PI_Q28)
        begin
            range_q16 = (longint'(mag) * INV_K + (longint'(1) << 27)) >> 28;
            t = (longint'(gain_lin) * range_q16) >> 8;
            c = floor_shift(cosine_q28(err), 8);
            if (c > 0)
            begin
                p = (t * c + (longint'(1) << 19)) >> 20;
                if (p > lim_fwd) p = lim_fwd;
                fwd = p;
            end
        end
        r.fwd = fwd[FWD_W-1:0];
        r.turn = ang[TURN_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        command_t want;
        if (!rst_n)
        begin
            gain_lin = 256;
            gain_ang = 512;
            lim_fwd = 65536;
            lim_turn = 131072;
            fail_count = 0;
            cmds_seen = 0;
            expected_cmds.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_GAIN_LINEAR:  gain_lin = cfg.data[GAIN_W-1:0];
                    REG_GAIN_ANGULAR: gain_ang = cfg.data[GAIN_W-1:0];
                    REG_MAX_LINEAR:   lim_fwd = cfg.data[LIM_W-1:0];
                    REG_MAX_TURN:     lim_turn = cfg.data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (pose.valid && pose.ready)
                expected_cmds.push_back(steer_command(pose.pose_x, pose.pose_y,
                    pose.quat_x, pose.quat_y, pose.quat_z, pose.quat_w,
                    pose.goal_x, pose.goal_y));
            if (cmd.valid && cmd.ready)
            begin
                cmds_seen++;
                if (expected_cmds.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: command with none expected: fwd %0d turn %0d",
                             $time, cmd.forward_speed, cmd.turn_rate);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (cmd.forward_speed !== want.fwd)
                    begin
                        fail_count++;
                        $display("%0t: forward_speed expected %0d actual %0d",
                                 $time, want.fwd, cmd.forward_speed);
                    end
                    if (cmd.turn_rate !== want.turn)
                    begin
                        fail_count++;
                        $display("%0t: turn_rate expected %0d actual %0d",
                                 $time, want.turn, cmd.turn_rate);
                    end
                end
            end
        end
        pending = expected_cmds.size();
    end
endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ddgp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    int   poses_sent;

    ddgp_in_if  pose ();
    ddgp_out_if cmd ();
    ddgp_cfg_if cfg ();

    diff_drive_goto_point_controller_core uut (
        .clk(clk), .rst_n(rst_n), .pose(pose.sink), .cmd(cmd.source), .cfg(cfg.sink)
    );

    ddgp_checker checker_i (
        .clk(clk), .rst_n(rst_n), .pose(pose), .cmd(cmd), .cfg(cfg),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // A stall on the command side: ready drops for a random number of cycles per transfer.
    initial
    begin
        int gap;
        cmd.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            repeat (gap)
            begin
                cmd.ready = 0;
                @(negedge clk);
            end
            cmd.ready = 1;
            do @(posedge clk); while (!cmd.valid);
        end
    end

    always @(posedge clk)
    begin
        if ((pose.valid && pose.ready) || (cmd.valid && cmd.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        cfg.index = idx;
        cfg.data = value;
        cfg.valid = 1;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 0;
    endtask

    task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz, logic signed [15:0] qw,
                             logic signed [31:0] gx, logic signed [31:0] gy,
                             bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            pose.valid = 0;
            repeat (gap) @(negedge clk);
        end
        pose.pose_x = px; pose.pose_y = py;
        pose.quat_x = qx; pose.quat_y = qy; pose.quat_z = qz; pose.quat_w = qw;
        pose.goal_x = gx; pose.goal_y = gy;
        pose.valid = 1;
        do @(posedge clk); while (!pose.ready);
        @(negedge clk);
        poses_sent++;
    endtask

    task automatic wait_drained();
        pose.valid = 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 32768) - 16384);
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return $signed($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    task automatic random_pose(bit burst);
        logic signed [31:0] px;
        logic signed [31:0] py;
        real    th;
        px = rand_pos();
        py = rand_pos();
        if ($urandom_range(0, 3) != 0)
        begin
            // Mostly unit yaw quaternions so the heading error covers the full circle.
            th = ($urandom_range(0, 62831) / 10000.0) - 3.14159;
            send_pose(px, py, 0, 0, 16'($rtoi(16384.0 * $sin(th / 2))),
                      16'($rtoi(16384.0 * $cos(th / 2))),
                      px + $signed($urandom_range(0, 1048576)) - 524288,
                      py + $signed($urandom_range(0, 1048576)) - 524288, burst);
        end
        else
            send_pose(px, py, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                      rand_pos(), rand_pos(), burst);
    endtask

    initial
    begin
        logic [31:0] gl_set[4] = '{256, 65535, 0, 1000};
        logic [31:0] ga_set[4] = '{512, 0, 65535, 100};
        logic [31:0] ml_set[4] = '{65536, 32'h7fffffff, 0, 300000};
        logic [31:0] mt_set[4] = '{131072, 0, 32'h7fffffff, 50000};
        rst_n = 0;
        pose.valid = 0;
        pose.pose_x = 0; pose.pose_y = 0; pose.goal_x = 0; pose.goal_y = 0;
        pose.quat_x = 0; pose.quat_y = 0; pose.quat_z = 0; pose.quat_w = 0;
        cfg.valid = 0; cfg.index = 0; cfg.data = 0;
        poses_sent = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: goal at pose, degenerate quaternion, extremes, wrap and right angles.
        send_pose(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(100, -5, 0, 0, 0, 16384, 100, -5, 0);
        send_pose(32'sh7fffffff, 32'sh80000000, 16384, 16384, 16384, 16384,
                  32'sh80000000, 32'sh7fffffff, 0);
        send_pose(32'sh80000000, 32'sh7fffffff, -16384, -16384, -16384, -16384,
                  32'sh7fffffff, 32'sh80000000, 0);
        send_pose(0, 0, 0, 0, 16384, 0, 65536, 0, 0);
        send_pose(0, 0, 0, 0, 16384, 0, -65536, 0, 0);
        send_pose(0, 0, 0, 0, 11585, 11585, 65536, 0, 0);
        send_pose(0, 0, 0, 0, -11585, 11585, 65536, 0, 0);
        send_pose(0, 0, 0, 0, 0, 16384, -65536, 1, 0);
        send_pose(0, 0, 0, 0, 0, 16384, -65536, -1, 0);
        send_pose(0, 0, 0, 0, 0, 16384, 0, 65536, 0);
        send_pose(0, 0, 0, 0, 0, -16384, 0, -65536, 0);
        send_pose(0, 0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 5, 5, 0);
        send_pose(0, 0, 0, 0, 0, 16384, 1000000, 0, 0);
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase < 4)
            begin
                write_reg(REG_GAIN_LINEAR, gl_set[phase]);
                write_reg(REG_GAIN_ANGULAR, ga_set[phase]);
                write_reg(REG_MAX_LINEAR, ml_set[phase]);
                write_reg(REG_MAX_TURN, mt_set[phase]);
            end
            else
            begin
                write_reg(REG_GAIN_LINEAR, $urandom_range(0, 65535));
                write_reg(REG_GAIN_ANGULAR, $urandom_range(0, 65535));
                write_reg(REG_MAX_LINEAR, $urandom());
                write_reg(REG_MAX_TURN, $urandom());
                // Out-of-range index must be ignored.
                write_reg(cfg_reg_t'(8'd9), $urandom());
            end
            for (int n = 0; n < 350; n++)
                random_pose((n / 40) % 2 == 1);
            wait_drained();
        end

        $display("Sent %0d poses over five gain and limit settings, zero and full-scale", poses_sent);
        $display("clips included, with random stalls on both channels.");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
